[hw/rtl/huffman_table_encoder_packer_core_macros.svh]
// Assertion helpers for the encoder blocks.
// Each macro expects i_clk and i_rst_n in scope.
`ifndef HUFFMAN_TABLE_ENCODER_PACKER_CORE_MACROS_SVH
`define HUFFMAN_TABLE_ENCODER_PACKER_CORE_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define HTE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a condition in the cycle after its trigger.
`define HTE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/hte_pkg.sv]
`timescale 1ns / 1ps

package hte_pkg;

    // Fixed field widths of the stream.
    localparam int CODE_BITS       = 32;
    localparam int LEN_BITS        = 6;
    localparam int SYM_BITS        = 8;
    localparam int BYTES_BITS      = 3;
    localparam int MAX_CODE_LEN    = 32;

    // Packer word geometry.
    localparam int WORD_BITS       = 32;
    localparam int WORD_BYTES      = (WORD_BITS + 7) / 8;
    localparam int FILL_BITS       = $clog2(WORD_BITS);
    localparam int TOTAL_BITS      = FILL_BITS + 1;

    // Defaults and sizes.
    localparam int TABLE_DEPTH_DEF = 256;
    localparam int QUEUE_DEPTH     = 4;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2,
        OP_UNUSED = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CMD_ENCODE = 2'd0,
        CMD_ERROR  = 2'd1,
        CMD_FLUSH  = 2'd2
    } t_kind;

    // Work item handed from the lookup side to the packer.
    typedef struct packed {
        t_kind                 kind;
        logic [CODE_BITS-1:0]  code;
        logic [LEN_BITS-1:0]   len;
    } t_cmd;

endpackage

[hw/rtl/hte_front.sv]
`timescale 1ns / 1ps

module hte_front #(
    parameter int TABLE_DEPTH = hte_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic [1:0]                     i_operation,
    input  logic [hte_pkg::SYM_BITS-1:0]   i_symbol,
    input  logic [hte_pkg::CODE_BITS-1:0]  i_code_bits,
    input  logic [hte_pkg::LEN_BITS-1:0]   i_code_length,
    output logic                           o_push,
    output hte_pkg::t_cmd                  o_cmd,
    input  logic                           i_full
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);

    logic [hte_pkg::CODE_BITS-1:0] r_code_mem [TABLE_DEPTH];
    logic [hte_pkg::LEN_BITS-1:0]  r_len_mem  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]        r_len_vld;

    logic                          r_s1_valid;
    logic                          r_s1_flush;
    logic                          r_s1_oor;
    logic [hte_pkg::CODE_BITS-1:0] r_rd_code;
    logic [hte_pkg::LEN_BITS-1:0]  r_rd_len;
    logic                          r_rd_vld;

    logic                          w_accept;
    logic                          w_in_range;
    logic [IDX_W-1:0]              w_idx;
    logic [hte_pkg::LEN_BITS-1:0]  w_len_clamp;
    logic                          w_is_load;
    logic                          w_to_s1;
    logic [hte_pkg::LEN_BITS-1:0]  w_len_eff;
    logic [hte_pkg::CODE_BITS-1:0] w_mask;

    // Accept whenever the lookup stage is empty or moves on
    assign o_stall  = r_s1_valid && i_full;
    assign w_accept = i_valid && !o_stall;

    // Classify the incoming item
    assign w_in_range  = {1'b0, i_symbol} < (hte_pkg::SYM_BITS + 1)'(TABLE_DEPTH);
    assign w_idx       = i_symbol[IDX_W-1:0];
    assign w_len_clamp = (i_code_length > hte_pkg::LEN_BITS'(hte_pkg::MAX_CODE_LEN)) ?
                         hte_pkg::LEN_BITS'(hte_pkg::MAX_CODE_LEN) : i_code_length;
    assign w_is_load   = (i_operation == hte_pkg::OP_LOAD);
    assign w_to_s1     = (i_operation == hte_pkg::OP_ENCODE) ||
                         (i_operation == hte_pkg::OP_FLUSH);

    // Write and read the code and length tables
    always_ff @(posedge i_clk) begin
        if (w_accept && w_is_load && w_in_range) begin
            r_code_mem[w_idx] <= i_code_bits;
            r_len_mem[w_idx]  <= w_len_clamp;
        end
        if (w_accept) begin
            r_rd_code  <= r_code_mem[w_idx];
            r_rd_len   <= r_len_mem[w_idx];
            r_s1_flush <= (i_operation == hte_pkg::OP_FLUSH);
            r_s1_oor   <= !w_in_range;
        end
    end

    // Track written entries and the lookup stage occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_vld  <= '0;
            r_s1_valid <= 1'b0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (w_accept && w_is_load && w_in_range) begin
                r_len_vld[w_idx] <= 1'b1;
            end
            if (w_accept) begin
                r_rd_vld   <= r_len_vld[w_idx];
                r_s1_valid <= w_to_s1;
            end else if (o_push) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    // Mask the code to its length and build the command
    assign w_len_eff = r_rd_vld ? r_rd_len : '0;
    assign w_mask    = (w_len_eff >= hte_pkg::LEN_BITS'(hte_pkg::CODE_BITS)) ? '1 :
                       hte_pkg::CODE_BITS'(({(hte_pkg::CODE_BITS + 1){1'b0}} | 1'b1)
                                           << w_len_eff) - hte_pkg::CODE_BITS'(1);

    always_comb begin
        o_cmd.code = r_rd_code & w_mask;
        o_cmd.len  = w_len_eff;
        if (r_s1_flush) begin
            o_cmd.kind = hte_pkg::CMD_FLUSH;
        end else if (r_s1_oor || (w_len_eff == '0)) begin
            o_cmd.kind = hte_pkg::CMD_ERROR;
        end else begin
            o_cmd.kind = hte_pkg::CMD_ENCODE;
        end
    end

    assign o_push = r_s1_valid && !i_full;

endmodule

[hw/rtl/hte_queue.sv]
`timescale 1ns / 1ps

module hte_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hte_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output hte_pkg::t_cmd o_cmd,
    input  logic          i_pop
);

    localparam int PTR_W = $clog2(hte_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(hte_pkg::QUEUE_DEPTH + 1);

    hte_pkg::t_cmd    r_mem [hte_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(hte_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    // Store pushed commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

[hw/rtl/hte_back.sv]
`timescale 1ns / 1ps
`include "huffman_table_encoder_packer_core_macros.svh"

module hte_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_q_valid,
    input  hte_pkg::t_cmd                    i_q_cmd,
    output logic                             o_q_pop,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [hte_pkg::CODE_BITS-1:0]    o_packed_word,
    output logic [hte_pkg::BYTES_BITS-1:0]   o_valid_bytes,
    output logic                             o_status,
    output logic                             o_last
);

    localparam int WB = hte_pkg::WORD_BITS;

    logic [WB-1:0]                      r_acc;
    logic [hte_pkg::FILL_BITS-1:0]      r_fill;
    logic                               r_valid;
    logic [hte_pkg::CODE_BITS-1:0]      r_word;
    logic [hte_pkg::BYTES_BITS-1:0]     r_bytes;
    logic                               r_status;
    logic                               r_last;

    logic                               w_pop;
    logic [hte_pkg::TOTAL_BITS-1:0]     w_total;
    logic [hte_pkg::TOTAL_BITS-1:0]     w_shamt;
    logic [2*WB-1:0]                    w_window;
    logic                               w_word_done;
    logic [hte_pkg::TOTAL_BITS-1:0]     w_fill_p7;

    // Take a command when the output register is free or being drained
    assign w_pop   = i_q_valid && (!r_valid || !i_stall);
    assign o_q_pop = w_pop;

    // Merge the code under the pending bits in a double-width window
    assign w_total     = hte_pkg::TOTAL_BITS'({1'b0, r_fill}) +
                         hte_pkg::TOTAL_BITS'(i_q_cmd.len);
    assign w_shamt     = hte_pkg::TOTAL_BITS'((hte_pkg::TOTAL_BITS + 1)'(2 * WB) -
                                              {1'b0, w_total});
    assign w_window    = {r_acc, {WB{1'b0}}} |
                         ({{WB{1'b0}}, WB'(i_q_cmd.code)} << w_shamt);
    assign w_word_done = (w_total >= hte_pkg::TOTAL_BITS'(WB));
    assign w_fill_p7   = hte_pkg::TOTAL_BITS'({1'b0, r_fill}) + hte_pkg::TOTAL_BITS'(7);

    // Pack, flush and hold the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_acc   <= '0;
            r_fill  <= '0;
        end else if (w_pop) begin
            unique case (i_q_cmd.kind)
                hte_pkg::CMD_ERROR: begin
                    r_valid  <= 1'b1;
                    r_word   <= '0;
                    r_bytes  <= '0;
                    r_status <= 1'b1;
                    r_last   <= 1'b0;
                end
                hte_pkg::CMD_FLUSH: begin
                    r_valid  <= 1'b1;
                    r_word   <= hte_pkg::CODE_BITS'(r_acc);
                    r_bytes  <= w_fill_p7[hte_pkg::TOTAL_BITS-1:3];
                    r_status <= 1'b0;
                    r_last   <= 1'b1;
                    r_acc    <= '0;
                    r_fill   <= '0;
                end
                hte_pkg::CMD_ENCODE: begin
                    r_fill <= w_total[hte_pkg::FILL_BITS-1:0];
                    if (w_word_done) begin
                        r_valid  <= 1'b1;
                        r_word   <= hte_pkg::CODE_BITS'(w_window[2*WB-1:WB]);
                        r_bytes  <= hte_pkg::BYTES_BITS'(hte_pkg::WORD_BYTES);
                        r_status <= 1'b0;
                        r_last   <= 1'b0;
                        r_acc    <= w_window[WB-1:0];
                    end else begin
                        r_valid <= 1'b0;
                        r_acc   <= w_window[2*WB-1:WB];
                    end
                end
                default: begin
                    r_valid <= 1'b0;
                end
            endcase
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    assign o_valid       = r_valid;
    assign o_packed_word = r_word;
    assign o_valid_bytes = r_bytes;
    assign o_status      = r_status;
    assign o_last        = r_last;

    `HTE_ASSERT_NOW(a_error_empty, r_valid && r_status, (r_word == '0) && (r_bytes == '0) && !r_last, "error result carries data")
    `HTE_ASSERT_NOW(a_word_bytes, r_valid && !r_status && !r_last, r_bytes == hte_pkg::BYTES_BITS'(hte_pkg::WORD_BYTES), "full word with short byte count")
    `HTE_ASSERT_NEXT(a_flush_clear, w_pop && (i_q_cmd.kind == hte_pkg::CMD_FLUSH), (r_fill == '0) && (r_acc == '0), "flush left pending bits")
    `HTE_ASSERT_NEXT(a_partial_quiet, w_pop && (i_q_cmd.kind == hte_pkg::CMD_ENCODE) && !w_word_done, !r_valid, "partial word produced a result")

endmodule

[hw/rtl/huffman_table_encoder_packer_core.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_stall   i_operation i_symbol i_code_bits i_code_length
// output    out        o_valid / i_stall   o_packed_word o_valid_bytes o_status o_last
//
// One item per cycle sustained while no stall holds the input; an encode or flush result
// passes from its transfer through the lookup register, the queue push and the packer register.
// Throughput is set by the single-port table read and the shift-and-merge packer.
// Reset is synchronous; the length table valid bits clear at once, no sweep needed.
// An output stall backs up a four-entry command queue, then the mask stage, then the input.

module huffman_table_encoder_packer_core #(
    parameter int TABLE_DEPTH = hte_pkg::TABLE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [1:0]                      i_operation,
    input  logic [hte_pkg::SYM_BITS-1:0]    i_symbol,
    input  logic [hte_pkg::CODE_BITS-1:0]   i_code_bits,
    input  logic [hte_pkg::LEN_BITS-1:0]    i_code_length,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [hte_pkg::CODE_BITS-1:0]   o_packed_word,
    output logic [hte_pkg::BYTES_BITS-1:0]  o_valid_bytes,
    output logic                            o_status,
    output logic                            o_last
);

    logic          w_push;
    hte_pkg::t_cmd w_push_cmd;
    logic          w_full;
    logic          w_q_valid;
    hte_pkg::t_cmd w_q_cmd;
    logic          w_pop;

    // Lookup side: classify items and read the tables
    hte_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_operation   (i_operation),
        .i_symbol      (i_symbol),
        .i_code_bits   (i_code_bits),
        .i_code_length (i_code_length),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd),
        .i_full        (w_full)
    );

    // Decouple lookup from packing
    hte_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_cmd   (w_q_cmd),
        .i_pop   (w_pop)
    );

    // Packing side: merge codes and emit words
    hte_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (w_q_valid),
        .i_q_cmd       (w_q_cmd),
        .o_q_pop       (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_packed_word (o_packed_word),
        .o_valid_bytes (o_valid_bytes),
        .o_status      (o_status),
        .o_last        (o_last)
    );

endmodule
